@@ rtl/ckd_pkg.sv @@
`timescale 1ns / 1ps
package ckd_pkg;

  typedef logic [7:0] u8_t;

  typedef enum logic [1:0] {
    CMD_IC_A  = 2'd0,
    CMD_IC_B  = 2'd1,
    CMD_CPU   = 2'd2,
    CMD_SPARE = 2'd3
  } cmd_t;

  localparam logic [1:0] CFG_PROJECT_LO = 2'd0;
  localparam logic [1:0] CFG_PROJECT_HI = 2'd1;

  typedef struct packed {
    logic [127:0] pj;
    u8_t          hash;
    u8_t          sum;
    logic         busy;
  } ckd_proj_t;

  localparam u8_t MIX_TAB [256] = '{
    8'h00,8'hFE,8'hFF,8'h01,8'hFD,8'h03,8'h02,8'hFC,8'hF9,8'h07,8'h06,8'hF8,8'h04,8'hFA,8'hFB,8'h05,
    8'hF1,8'h0F,8'h0E,8'hF0,8'h0C,8'hF2,8'hF3,8'h0D,8'h08,8'hF6,8'hF7,8'h09,8'hF5,8'h0B,8'h0A,8'hF4,
    8'hE1,8'h1F,8'h1E,8'hE0,8'h1C,8'hE2,8'hE3,8'h1D,8'h18,8'hE6,8'hE7,8'h19,8'hE5,8'h1B,8'h1A,8'hE4,
    8'h10,8'hEE,8'hEF,8'h11,8'hED,8'h13,8'h12,8'hEC,8'hE9,8'h17,8'h16,8'hE8,8'h14,8'hEA,8'hEB,8'h15,
    8'hC1,8'h3F,8'h3E,8'hC0,8'h3C,8'hC2,8'hC3,8'h3D,8'h38,8'hC6,8'hC7,8'h39,8'hC5,8'h3B,8'h3A,8'hC4,
    8'h30,8'hCE,8'hCF,8'h31,8'hCD,8'h33,8'h32,8'hCC,8'hC9,8'h37,8'h36,8'hC8,8'h34,8'hCA,8'hCB,8'h35,
    8'h20,8'hDE,8'hDF,8'h21,8'hDD,8'h23,8'h22,8'hDC,8'hD9,8'h27,8'h26,8'hD8,8'h24,8'hDA,8'hDB,8'h25,
    8'hD1,8'h2F,8'h2E,8'hD0,8'h2C,8'hD2,8'hD3,8'h2D,8'h28,8'hD6,8'hD7,8'h29,8'hD5,8'h2B,8'h2A,8'hD4,
    8'h81,8'h7F,8'h7E,8'h80,8'h7C,8'h82,8'h83,8'h7D,8'h78,8'h86,8'h87,8'h79,8'h85,8'h7B,8'h7A,8'h84,
    8'h70,8'h8E,8'h8F,8'h71,8'h8D,8'h73,8'h72,8'h8C,8'h89,8'h77,8'h76,8'h88,8'h74,8'h8A,8'h8B,8'h75,
    8'h60,8'h9E,8'h9F,8'h61,8'h9D,8'h63,8'h62,8'h9C,8'h99,8'h67,8'h66,8'h98,8'h64,8'h9A,8'h9B,8'h65,
    8'h91,8'h6F,8'h6E,8'h90,8'h6C,8'h92,8'h93,8'h6D,8'h68,8'h96,8'h97,8'h69,8'h95,8'h6B,8'h6A,8'h94,
    8'h40,8'hBE,8'hBF,8'h41,8'hBD,8'h43,8'h42,8'hBC,8'hB9,8'h47,8'h46,8'hB8,8'h44,8'hBA,8'hBB,8'h45,
    8'hB1,8'h4F,8'h4E,8'hB0,8'h4C,8'hB2,8'hB3,8'h4D,8'h48,8'hB6,8'hB7,8'h49,8'hB5,8'h4B,8'h4A,8'hB4,
    8'hA1,8'h5F,8'h5E,8'hA0,8'h5C,8'hA2,8'hA3,8'h5D,8'h58,8'hA6,8'hA7,8'h59,8'hA5,8'h5B,8'h5A,8'hA4,
    8'h50,8'hAE,8'hAF,8'h51,8'hAD,8'h53,8'h52,8'hAC,8'hA9,8'h57,8'h56,8'hA8,8'h54,8'hAA,8'hAB,8'h55
  };

  function automatic u8_t tstep(u8_t h, u8_t b);
    return MIX_TAB[h ^ b];
  endfunction

endpackage

@@ rtl/ckd_in_if.sv @@
`timescale 1ns / 1ps
interface ckd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] card_id;
  logic [7:0]  sector;
  logic [15:0] app_id;
  logic [7:0]  target_key_id;
  modport source (output valid, cmd, card_id, sector, app_id, target_key_id, input ready);
  modport sink (input valid, cmd, card_id, sector, app_id, target_key_id, output ready);
endinterface

@@ rtl/ckd_out_if.sv @@
`timescale 1ns / 1ps
interface ckd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_lo;
  logic [63:0] key_hi;
  modport source (output valid, key_lo, key_hi, input ready);
  modport sink (input valid, key_lo, key_hi, output ready);
endinterface

@@ rtl/ckd_cfg_if.sv @@
`timescale 1ns / 1ps
interface ckd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/ckd_proj_walker.sv @@
`timescale 1ns / 1ps
module ckd_proj_walker (
  input  logic              clk,
  input  logic              rst_n,
  ckd_cfg_if.sink           cfg_ch,
  output ckd_pkg::ckd_proj_t proj
);
  import ckd_pkg::*;

  logic [127:0] pj_r, pj_nxt;
  logic         busy_r, busy_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  u8_t          h_r, h_nxt, s_r, s_nxt;
  u8_t          cur;
  logic         wr;

  assign cfg_ch.ready = 1'b1;
  assign wr  = cfg_ch.valid;
  assign cur = pj_r[{cnt_r, 3'b000} +: 8];

  always_comb begin
    pj_nxt   = pj_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    h_nxt    = h_r;
    s_nxt    = s_r;
    if (busy_r) begin
      h_nxt   = tstep(h_r, cur);
      s_nxt   = s_r + cur;
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) busy_nxt = 1'b0;
    end
    // restart the walk over the new name
    if (wr) begin
      case (cfg_ch.index)
        CFG_PROJECT_LO: pj_nxt[63:0]   = cfg_ch.data;
        CFG_PROJECT_HI: pj_nxt[127:64] = cfg_ch.data;
        default:        pj_nxt         = pj_r;
      endcase
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd0;
      h_nxt    = 8'h00;
      s_nxt    = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pj_r   <= '0;
      busy_r <= 1'b1;
      cnt_r  <= 4'd0;
      h_r    <= 8'h00;
      s_r    <= 8'h00;
    end else begin
      pj_r   <= pj_nxt;
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      h_r    <= h_nxt;
      s_r    <= s_nxt;
    end
  end

  assign proj.pj   = pj_r;
  assign proj.hash = h_r;
  assign proj.sum  = s_r;
  assign proj.busy = busy_r;
endmodule

@@ rtl/card_key_diversifier.sv @@
`timescale 1ns / 1ps
// Card key diversifier.
// in_ch  : request item (cmd, card_id, sector, app_id, target_key_id).
// out_ch : key item (key_lo, key_hi); IC modes fill bytes 0-5 only.
// cfg_ch : project name writes, index 0 low half, index 1 high half;
//          always ready.
// Throughput is one item per cycle while the receiver does not stall and no
// walk runs. A request moves through the valid registers v1_r to v6_r, and
// out_ch.valid is v6_r. The pipeline has six stages of chained table
// lookups, at most about six lookups deep per stage.
// After reset and after every configuration write, a walk over the 16 name
// bytes hashes the project name; in_ch.ready stays low during it.
// When the receiver stalls, the whole pipeline holds; in_ch.ready drops
// during the walk and while the output register holds an untaken item.
// Reset clears valid bits and the project name and starts the walk.
module card_key_diversifier (
  input  logic    clk,
  input  logic    rst_n,
  ckd_in_if.sink  in_ch,
  ckd_out_if.source out_ch,
  ckd_cfg_if.sink cfg_ch
);
  import ckd_pkg::*;

  ckd_proj_t proj;

  ckd_proj_walker u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .proj  (proj)
  );

  function automatic u8_t hcont(u8_t h, logic [47:0] b, int n);
    u8_t x;
    x = h;
    for (int i = 0; i < 6; i++) begin
      if (i < n) x = tstep(x, b[8*i +: 8]);
    end
    return x;
  endfunction

  function automatic logic [23:0] base_head(logic tb, logic [31:0] id);
    u8_t h, s, k0, k1, k2;
    u8_t i0, i1, i2, i3;
    i0 = id[7:0]; i1 = id[15:8]; i2 = id[23:16]; i3 = id[31:24];
    h = hcont(8'h00, {16'h0000, id}, 4);
    s = i0 + i1 + i2 + i3;
    if (tb) begin
      k0 = (i0 ^ 8'h0C) + (i1 ^ 8'h0A) + (i2 ^ 8'hC0) + (i3 ^ 8'hA0)
         + (i2 ^ 8'hCA) + (i1 ^ 8'hAC);
      k1 = h ^ 8'h5a;
      k2 = s ^ 8'ha5;
    end else begin
      k0 = h ^ 8'ha5;
      k1 = s ^ 8'h5a;
      k2 = (i0 ^ 8'h03) + (i1 ^ 8'h05) + (i2 ^ 8'h30) + (i3 ^ 8'h50)
         + (i2 ^ 8'h35) + (i1 ^ 8'h53);
    end
    return {k2, k1, k0};
  endfunction

  function automatic logic [47:0] tail(logic [23:0] k);
    u8_t h3, k3, k4, k5;
    h3 = hcont(8'h00, {24'h0, k}, 3);
    k3 = ~h3;
    k4 = k[7:0] + k[15:8] + k[23:16] + k3;
    k5 = tstep(tstep(h3, k3), k4);
    return {k5, k4, k3, k};
  endfunction

  function automatic logic [47:0] ic_out(logic [47:0] k, u8_t sec, logic [127:0] pj,
                                         u8_t pjh, u8_t s);
    u8_t t, o0, o1, o2, o3, o4, o5, h2;
    t  = tstep(pjh, sec);
    o0 = k[31:24] + pj[7:0] + t + k[39:32];
    o1 = k[23:16] + (s ^ t);
    h2 = tstep(tstep(8'h00, o0), o1);
    o2 = ~h2 + s;
    o3 = k[7:0] + (pj[31:24] ^ s) + pj[111:104] + k[15:8] + (pj[87:80] ^ t)
       + pj[47:40];
    o4 = k[47:40] + (s ^ t);
    o5 = tstep(tstep(tstep(h2, o2), o3), o4);
    return {o5, o4, o3, o2, o1, o0};
  endfunction

  function automatic u8_t sum6(logic [47:0] b);
    return b[7:0] + b[15:8] + b[23:16] + b[31:24] + b[39:32] + b[47:40];
  endfunction

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] id;
    logic [15:0] app;
    u8_t         kid;
    u8_t         sec;
  } req_t;

  logic        en;
  logic        v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  req_t        rq1_r, rq2_r, rq3_r, rq4_r, rq5_r;
  logic [23:0] ick1_r, cak1_r;
  logic [31:0] b2_1_r;
  logic [47:0] ick2_r, cak2_r, cak3_r, cak4_r, cak5_r;
  logic [23:0] sk2_r;
  logic [47:0] sk3_r, ico3_r, ico4_r, ico5_r, hi4_r, hi5_r;
  u8_t         hk4_r, hp5_r, k12_r, k13_r, k14_r;
  logic [63:0] lo6_r, hi6_r;

  req_t        rq0;
  u8_t         hid, ids, k15;
  logic [23:0] ick1_nxt, cak1_nxt;
  logic [31:0] b2_1_nxt;
  u8_t         k12_nxt, k13_nxt, k14_nxt, hp5_nxt;
  logic [63:0] lo6_nxt, hi6_nxt;

  assign en          = !v6_r || out_ch.ready;
  assign in_ch.ready = en && !proj.busy;

  always_comb begin
    rq0.cmd = in_ch.cmd;
    rq0.id  = in_ch.card_id;
    rq0.app = in_ch.app_id;
    rq0.kid = in_ch.target_key_id;
    rq0.sec = in_ch.sector;
    hid = hcont(8'h00, {16'h0000, rq0.id}, 4);
    ids = rq0.id[7:0] + rq0.id[15:8] + rq0.id[23:16] + rq0.id[31:24];
    ick1_nxt = base_head(rq0.cmd != CMD_IC_A, rq0.id);
    cak1_nxt = base_head(1'b1, {proj.hash, rq0.kid, rq0.app[15:8], rq0.app[7:0] + ids});
    b2_1_nxt = {rq0.id[31:24] + 8'hA5, rq0.id[23:16] + rq0.kid,
                rq0.id[15:8] + hid, rq0.id[7:0] + ids + 8'h5A};
  end

  always_comb begin
    k12_nxt = sum6(cak4_r) + sum6(hi4_r) + 8'h85 + rq4_r.kid;
    k13_nxt = rq4_r.app[7:0] + rq4_r.app[15:8] + rq4_r.kid + hcont(8'h00, hi4_r, 6);
    k14_nxt = (rq4_r.id[7:0] ^ 8'h5a) + (proj.pj[87:80] ^ 8'h65) + sum6(cak4_r);
    hp5_nxt = hcont(hk4_r, hi4_r, 6);
  end

  always_comb begin
    k15 = hcont(hp5_r, {24'h0, k14_r, k13_r, k12_r}, 3) + 8'h55;
    if (rq5_r.cmd == CMD_CPU) begin
      lo6_nxt = {hi5_r[15:0], cak5_r};
      hi6_nxt = {k15, k14_r, k13_r, k12_r, hi5_r[47:16]};
    end else begin
      lo6_nxt = {16'h0000, ico5_r};
      hi6_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r} <= '0;
    end else if (en) begin
      v1_r <= in_ch.valid && in_ch.ready;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // payload advances with the valid bits; hold all on stall
  always_ff @(posedge clk) begin
    if (en) begin
      rq1_r  <= rq0;
      ick1_r <= ick1_nxt;
      cak1_r <= cak1_nxt;
      b2_1_r <= b2_1_nxt;

      rq2_r  <= rq1_r;
      ick2_r <= tail(ick1_r);
      cak2_r <= tail(cak1_r);
      sk2_r  <= base_head(1'b0, b2_1_r);

      rq3_r  <= rq2_r;
      sk3_r  <= tail(sk2_r);
      ico3_r <= ic_out(ick2_r, rq2_r.sec, proj.pj, proj.hash, proj.sum);
      cak3_r <= cak2_r;

      rq4_r  <= rq3_r;
      hi4_r  <= ic_out(sk3_r, rq3_r.kid + rq3_r.app[7:0], proj.pj, proj.hash, proj.sum);
      hk4_r  <= hcont(8'h00, cak3_r, 6);
      cak4_r <= cak3_r;
      ico4_r <= ico3_r;

      rq5_r  <= rq4_r;
      k12_r  <= k12_nxt;
      k13_r  <= k13_nxt;
      k14_r  <= k14_nxt;
      hp5_r  <= hp5_nxt;
      hi5_r  <= hi4_r;
      cak5_r <= cak4_r;
      ico5_r <= ico4_r;

      lo6_r  <= lo6_nxt;
      hi6_r  <= hi6_nxt;
    end
  end

  assign out_ch.valid  = v6_r;
  assign out_ch.key_lo = lo6_r;
  assign out_ch.key_hi = hi6_r;
endmodule

@@ verif/ckd_tb_if.sv @@
`timescale 1ns / 1ps
// Interfaces are provided by the RTL; this file holds the key and request item types shared by the bench.
package ckd_tb_pkg;

  typedef struct packed {
    logic [63:0] key_lo;
    logic [63:0] key_hi;
  } key_item_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] card_id;
    logic [7:0]  sector;
    logic [15:0] app_id;
    logic [7:0]  target_key_id;
  } req_item_t;

endpackage

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import ckd_pkg::*;
  import ckd_tb_pkg::*;

  logic clk;
  logic rst_n;

  ckd_in_if  in_ch ();
  ckd_out_if out_ch ();
  ckd_cfg_if cfg_ch ();

  card_key_diversifier uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  localparam u8_t HASH_TAB [256] = '{
    8'h00,8'hFE,8'hFF,8'h01,8'hFD,8'h03,8'h02,8'hFC,8'hF9,8'h07,8'h06,8'hF8,8'h04,8'hFA,8'hFB,8'h05,
    8'hF1,8'h0F,8'h0E,8'hF0,8'h0C,8'hF2,8'hF3,8'h0D,8'h08,8'hF6,8'hF7,8'h09,8'hF5,8'h0B,8'h0A,8'hF4,
    8'hE1,8'h1F,8'h1E,8'hE0,8'h1C,8'hE2,8'hE3,8'h1D,8'h18,8'hE6,8'hE7,8'h19,8'hE5,8'h1B,8'h1A,8'hE4,
    8'h10,8'hEE,8'hEF,8'h11,8'hED,8'h13,8'h12,8'hEC,8'hE9,8'h17,8'h16,8'hE8,8'h14,8'hEA,8'hEB,8'h15,
    8'hC1,8'h3F,8'h3E,8'hC0,8'h3C,8'hC2,8'hC3,8'h3D,8'h38,8'hC6,8'hC7,8'h39,8'hC5,8'h3B,8'h3A,8'hC4,
    8'h30,8'hCE,8'hCF,8'h31,8'hCD,8'h33,8'h32,8'hCC,8'hC9,8'h37,8'h36,8'hC8,8'h34,8'hCA,8'hCB,8'h35,
    8'h20,8'hDE,8'hDF,8'h21,8'hDD,8'h23,8'h22,8'hDC,8'hD9,8'h27,8'h26,8'hD8,8'h24,8'hDA,8'hDB,8'h25,
    8'hD1,8'h2F,8'h2E,8'hD0,8'h2C,8'hD2,8'hD3,8'h2D,8'h28,8'hD6,8'hD7,8'h29,8'hD5,8'h2B,8'h2A,8'hD4,
    8'h81,8'h7F,8'h7E,8'h80,8'h7C,8'h82,8'h83,8'h7D,8'h78,8'h86,8'h87,8'h79,8'h85,8'h7B,8'h7A,8'h84,
    8'h70,8'h8E,8'h8F,8'h71,8'h8D,8'h73,8'h72,8'h8C,8'h89,8'h77,8'h76,8'h88,8'h74,8'h8A,8'h8B,8'h75,
    8'h60,8'h9E,8'h9F,8'h61,8'h9D,8'h63,8'h62,8'h9C,8'h99,8'h67,8'h66,8'h98,8'h64,8'h9A,8'h9B,8'h65,
    8'h91,8'h6F,8'h6E,8'h90,8'h6C,8'h92,8'h93,8'h6D,8'h68,8'h96,8'h97,8'h69,8'h95,8'h6B,8'h6A,8'h94,
    8'h40,8'hBE,8'hBF,8'h41,8'hBD,8'h43,8'h42,8'hBC,8'hB9,8'h47,8'h46,8'hB8,8'h44,8'hBA,8'hBB,8'h45,
    8'hB1,8'h4F,8'h4E,8'hB0,8'h4C,8'hB2,8'hB3,8'h4D,8'h48,8'hB6,8'hB7,8'h49,8'hB5,8'h4B,8'h4A,8'hB4,
    8'hA1,8'h5F,8'h5E,8'hA0,8'h5C,8'hA2,8'hA3,8'h5D,8'h58,8'hA6,8'hA7,8'h59,8'hA5,8'h5B,8'h5A,8'hA4,
    8'h50,8'hAE,8'hAF,8'h51,8'hAD,8'h53,8'h52,8'hAC,8'hA9,8'h57,8'h56,8'hA8,8'h54,8'hAA,8'hAB,8'h55
  };

  typedef u8_t bytes16_t [16];

  logic [63:0] proj_lo_q, proj_hi_q;
  key_item_t   pending_keys [$];
  int          err_count;
  int          key_count;
  int          sent_count;
  int          send_idle_pct, recv_stall_pct;

  function automatic u8_t hash_n(bytes16_t p, int off, int n);
    u8_t h;
    h = 8'h00;
    for (int i = 0; i < n; i++) h = HASH_TAB[h ^ p[off + i]];
    return h;
  endfunction

  function automatic u8_t sum_n(bytes16_t p, int off, int n);
    u8_t s;
    s = 8'h00;
    for (int i = 0; i < n; i++) s = s + p[off + i];
    return s;
  endfunction

  // derive the six-byte base key into k[off..off+5] from four id bytes
  function automatic void base_key(bit type_b, u8_t id [4], ref bytes16_t k, input int off);
    bytes16_t t;
    for (int i = 0; i < 16; i++) t[i] = 8'h00;
    for (int i = 0; i < 4; i++) t[i] = id[i];
    if (type_b) begin
      k[off] = (id[0] ^ 8'h0C) + (id[1] ^ 8'h0A) + (id[2] ^ 8'hC0) + (id[3] ^ 8'hA0)
             + (id[2] ^ 8'hCA) + (id[1] ^ 8'hAC);
      k[off+1] = hash_n(t, 0, 4) ^ 8'h5a;
      k[off+2] = sum_n(t, 0, 4) ^ 8'ha5;
    end else begin
      k[off] = hash_n(t, 0, 4) ^ 8'ha5;
      k[off+1] = sum_n(t, 0, 4) ^ 8'h5a;
      k[off+2] = (id[0] ^ 8'h03) + (id[1] ^ 8'h05) + (id[2] ^ 8'h30) + (id[3] ^ 8'h50)
               + (id[2] ^ 8'h35) + (id[1] ^ 8'h53);
    end
    k[off+3] = ~hash_n(k, off, 3);
    k[off+4] = sum_n(k, off, 4);
    k[off+5] = hash_n(k, off, 5);
  endfunction

  function automatic void ic_derive(bit type_b, u8_t id [4], u8_t sec, bytes16_t pj,
                                    ref bytes16_t o, input int off);
    bytes16_t k;
    u8_t t, s;
    for (int i = 0; i < 16; i++) k[i] = 8'h00;
    base_key(type_b, id, k, 0);
    t = HASH_TAB[hash_n(pj, 0, 16) ^ sec];
    s = sum_n(pj, 0, 16);
    o[off]   = k[3] + pj[0] + t + k[4];
    o[off+1] = k[2] + (s ^ t);
    o[off+2] = u8_t'(~hash_n(o, off, 2)) + s;
    o[off+3] = k[0] + (pj[3] ^ s) + pj[13] + k[1] + (pj[10] ^ t) + pj[5];
    o[off+4] = k[5] + (s ^ t);
    o[off+5] = hash_n(o, off, 5);
  endfunction

  function automatic key_item_t derive_key(req_item_t r, logic [63:0] plo, logic [63:0] phi);
    bytes16_t pj, k, idb;
    u8_t id [4], b [4], app0, app1, kid, ids;
    key_item_t res;
    for (int i = 0; i < 8; i++) begin
      pj[i] = plo[8*i +: 8];
      pj[8+i] = phi[8*i +: 8];
    end
    for (int i = 0; i < 16; i++) begin
      k[i] = 8'h00;
      idb[i] = 8'h00;
    end
    for (int i = 0; i < 4; i++) begin
      id[i] = r.card_id[8*i +: 8];
      idb[i] = id[i];
    end
    app0 = r.app_id[7:0];
    app1 = r.app_id[15:8];
    kid = r.target_key_id;
    if (r.cmd == CMD_CPU) begin
      ids = sum_n(idb, 0, 4);
      b[0] = app0 + ids;
      b[1] = app1;
      b[2] = kid;
      b[3] = hash_n(pj, 0, 16);
      base_key(1'b1, b, k, 0);
      b[0] = id[0] + ids + 8'h5A;
      b[1] = id[1] + hash_n(idb, 0, 4);
      b[2] = id[2] + kid;
      b[3] = id[3] + 8'hA5;
      ic_derive(1'b0, b, kid + app0, pj, k, 6);
      k[12] = sum_n(k, 0, 12) + 8'h85 + kid;
      k[13] = app0 + app1 + kid + hash_n(k, 6, 6);
      k[14] = (id[0] ^ 8'h5a) + (pj[10] ^ 8'h65) + sum_n(k, 0, 6);
      k[15] = hash_n(k, 0, 15) + 8'h55;
    end else begin
      // spare code falls into type B
      ic_derive(r.cmd != CMD_IC_A, id, r.sector, pj, k, 0);
    end
    for (int i = 0; i < 8; i++) begin
      res.key_lo[8*i +: 8] = k[i];
      res.key_hi[8*i +: 8] = k[8+i];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %016h want %016h", what, got, want);
    err_count++;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAIL card_key_diversifier");
    $finish;
  end

  // receiver side: random stall and compare against the oldest key
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        key_count++;
        if (pending_keys.size() == 0) begin
          report_mismatch("unexpected item", out_ch.key_lo, 64'h0);
        end else begin
          key_item_t w;
          w = pending_keys.pop_front();
          if (out_ch.key_lo !== w.key_lo) report_mismatch("key_lo", out_ch.key_lo, w.key_lo);
          if (out_ch.key_hi !== w.key_hi) report_mismatch("key_hi", out_ch.key_hi, w.key_hi);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_PROJECT_LO) proj_lo_q = val;
    else proj_hi_q = val;
  endtask

  // hold valid until accepted; predict at acceptance
  task automatic send_req(req_item_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= r.cmd;
    in_ch.card_id <= r.card_id;
    in_ch.sector <= r.sector;
    in_ch.app_id <= r.app_id;
    in_ch.target_key_id <= r.target_key_id;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_keys.push_back(derive_key(r, proj_lo_q, proj_hi_q));
    sent_count++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic req_item_t rand_req();
    req_item_t r;
    r.cmd = (($urandom_range(15)) == 0) ? CMD_SPARE : cmd_t'($urandom_range(2));
    r.card_id = $urandom;
    r.sector = 8'($urandom);
    r.app_id = 16'($urandom);
    r.target_key_id = 8'($urandom);
    return r;
  endfunction

  req_item_t   dir_req [16];
  logic [63:0] dir_lo [16];
  logic        dir_known [16];
  logic [63:0] proj_set [5][2];

  initial begin
    key_item_t w;
    err_count = 0;
    key_count = 0;
    sent_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    proj_lo_q = 64'h0;
    proj_hi_q = 64'h0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_IC_A;
    in_ch.card_id = '0;
    in_ch.sector = '0;
    in_ch.app_id = '0;
    in_ch.target_key_id = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_PROJECT_LO;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;

    // all-zero project, zero card: key A low bytes read off by hand
    dir_req[0] = '{CMD_IC_A, 32'h0, 8'h00, 16'h0, 8'h00};
    dir_known[0] = 1'b1;
    dir_lo[0] = 64'h0000_C83D_FFA1_1015;
    dir_req[1] = '{CMD_IC_B, 32'h0, 8'h00, 16'h0, 8'h00};
    dir_req[2] = '{CMD_CPU, 32'h0, 8'h00, 16'h0, 8'h00};
    dir_req[3] = '{CMD_SPARE, 32'h0, 8'h00, 16'h0, 8'h00};
    dir_req[4] = '{CMD_IC_A, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'hFF};
    dir_req[5] = '{CMD_IC_B, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'hFF};
    dir_req[6] = '{CMD_CPU, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'hFF};
    dir_req[7] = '{CMD_SPARE, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 8'hFF};
    dir_req[8] = '{CMD_IC_A, 32'h1234_5678, 8'h0F, 16'hABCD, 8'h55};
    dir_req[9] = '{CMD_IC_B, 32'h8000_0001, 8'h80, 16'h0001, 8'h01};
    dir_req[10] = '{CMD_CPU, 32'h8000_0001, 8'h80, 16'h8000, 8'h80};
    dir_req[11] = '{CMD_CPU, 32'h1234_5678, 8'h00, 16'h00FF, 8'hAA};
    dir_req[12] = '{CMD_IC_A, 32'h1234_5678, 8'hAA, 16'h0, 8'h00};
    dir_req[13] = '{CMD_CPU, 32'hDEAD_BEEF, 8'h33, 16'hFF00, 8'h00};
    dir_req[14] = '{CMD_IC_B, 32'h00FF_00FF, 8'h01, 16'hFFFF, 8'hFF};
    dir_req[15] = '{CMD_SPARE, 32'hA5A5_5A5A, 8'hFE, 16'h1234, 8'h7F};
    for (int i = 1; i < 16; i++) dir_known[i] = 1'b0;

    proj_set[0] = '{64'h0, 64'h0};
    proj_set[1] = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
    proj_set[2] = '{64'h3130_3938_3736_3534, 64'h0000_0000_4A4B_4C4D};
    proj_set[3] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF};
    proj_set[4] = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 16; i++) begin
      if (dir_known[i]) begin
        w = derive_key(dir_req[i], proj_lo_q, proj_hi_q);
        if (w.key_lo !== dir_lo[i] || w.key_hi !== 64'h0)
          report_mismatch("table row", w.key_lo, dir_lo[i]);
      end
      send_req(dir_req[i]);
    end
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 5) begin
        cfg_write(CFG_PROJECT_LO, proj_set[ph][0]);
        cfg_write(CFG_PROJECT_HI, proj_set[ph][1]);
      end else begin
        cfg_write(CFG_PROJECT_LO, {$urandom, $urandom});
        cfg_write(CFG_PROJECT_HI, {$urandom, $urandom});
      end
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 52; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 52; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (int n = 0; n < 180; n++) begin
        send_req(rand_req());
        // pause until the pipe is empty, then resume
        if (n == 90) begin
          in_ch.valid <= 1'b0;
          while (pending_keys.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("covered %0d requests, %0d keys, across 8 project settings and 4 stall mixes",
             sent_count, key_count);
    if (err_count == 0) begin
      $display("PASS card_key_diversifier");
    end else begin
      $display("%0d mismatches", err_count);
      $display("FAIL card_key_diversifier");
    end
    $finish;
  end

endmodule
